@@ src/gef_pkg.sv @@
package gef_pkg;

   localparam int NET_W = 10;

   typedef enum logic [1:0] {
      KIND_SET  = 2'd0,
      KIND_EVAL = 2'd1,
      KIND_ENUM = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      GATE_AND  = 3'd0,
      GATE_NAND = 3'd1,
      GATE_OR   = 3'd2,
      GATE_NOR  = 3'd3,
      GATE_XOR  = 3'd4,
      GATE_XNOR = 3'd5,
      GATE_BUF  = 3'd6,
      GATE_NOT  = 3'd7
   } gate_op_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [2:0]       gate_type;
      logic [2:0]       fanin;
      logic [NET_W-1:0] in_net0;
      logic [NET_W-1:0] in_net1;
      logic [NET_W-1:0] in_net2;
      logic [NET_W-1:0] in_net3;
      logic [NET_W-1:0] out_net;
      logic             set_value;
   } req_type;

   typedef struct packed {
      logic             net_value;
      logic [NET_W-1:0] fault_net;
      logic             fault_value;
      logic [NET_W-1:0] effect_net;
      logic             effect_value;
      logic             last;
   } rsp_type;

   function automatic logic gate_fn(input logic [2:0] gt, input logic [3:0] v,
                                    input logic [3:0] used);
      logic a;
      logic o;
      logic x;
      a = &(v | ~used);
      o = |(v & used);
      x = ^(v & used);
      case (gt)
         GATE_AND:  gate_fn = a;
         GATE_NAND: gate_fn = ~a;
         GATE_OR:   gate_fn = o;
         GATE_NOR:  gate_fn = ~o;
         GATE_XOR:  gate_fn = x;
         GATE_XNOR: gate_fn = ~x;
         GATE_BUF:  gate_fn = v[0];
         default:   gate_fn = ~v[0];
      endcase
   endfunction

endpackage

@@ src/gef_ram.sv @@
module gef_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ src/gef_front.sv @@
// Classifies items: clamps fanin, builds the use mask, queues them.
module gef_front
   import gef_pkg::*;
#(
   parameter int MAX_FANIN = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    q_valid,
   input  logic    q_take,
   output req_type q_item,
   output logic [3:0] q_used
);
   localparam int LIM = (MAX_FANIN < 4) ? MAX_FANIN : 4;

   req_type    slot_ff [2];
   logic [3:0] used_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] n;
   logic [3:0] used;
   logic       push;

   always_comb begin
      n = req_item.fanin;
      if (n == 3'd0) n = 3'd1;
      if (n > 3'(LIM)) n = 3'(LIM);
      if (req_item.gate_type[2:1] == 2'b11) n = 3'd1;
      used = 4'((5'd1 << n) - 5'd1);
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rp_ff];
   assign q_used    = used_ff[rp_ff];
   assign wp_in     = wp_ff ^ push;
   assign rp_in     = rp_ff ^ q_take;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(q_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= req_item;
         used_ff[wp_ff] <= used;
      end
   end

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("take from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |=> (cnt_ff != 2'd2)) else $error("queue count jump");
endmodule

@@ src/gef_back.sv @@
// Executes items against the net store; one net read per cycle.
module gef_back
   import gef_pkg::*;
#(
   parameter int NET_COUNT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_take,
   input  req_type    q_item,
   input  logic [3:0] q_used,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_item
);
   localparam int AW = (NET_COUNT > 1) ? $clog2(NET_COUNT) : 1;
   localparam int DEPTH = 1 << AW;
   localparam logic [NET_W:0] NET_LIM = (NET_COUNT >= (1 << NET_W))
                                        ? (NET_W+1)'(1 << NET_W) : (NET_W+1)'(NET_COUNT);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_EXEC  = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_SETW  = 7'b1000000
   } state_type;

   state_type     st_ff, st_in;
   req_type       it_ff;
   logic [3:0]    used_ff;
   logic [2:0]    rc_ff, rc_in;
   logic [2:0]    vc_ff, vc_in;
   logic [4:0]    vals_ff, vals_in;
   logic [2:0]    ec_ff, ec_in;
   logic [AW:0]   clr_ff, clr_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_data, rd_data;
   logic          rd_req_ff, rd_req_in;
   logic          rd_ok_ff, rd_ok_in;
   logic [NET_W-1:0] nets [5];
   logic [NET_W-1:0] rnet;
   logic          eval_bit;
   logic [3:0]    fv;
   logic [NET_W-1:0] knet;
   rsp_type       r;
   logic          out_ok;

   assign nets[0] = it_ff.in_net0;
   assign nets[1] = it_ff.in_net1;
   assign nets[2] = it_ff.in_net2;
   assign nets[3] = it_ff.in_net3;
   assign nets[4] = it_ff.out_net;
   assign rnet    = nets[rc_ff];
   assign out_ok  = !rsp_valid || !rsp_stall;

   gef_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign rd_addr  = AW'(rnet);
   assign eval_bit = gate_fn(it_ff.gate_type, vals_ff[3:0], used_ff);
   assign knet     = nets[ec_ff];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         fv[i] = vals_ff[i] ^ (nets[i] == knet);
      end
   end

   always_comb begin
      st_in     = st_ff;
      rc_in     = rc_ff;
      vc_in     = vc_ff;
      vals_in   = vals_ff;
      ec_in     = ec_ff;
      clr_in    = clr_ff;
      rd_req_in = 1'b0;
      rd_ok_in  = rd_ok_ff;
      q_take    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = AW'(it_ff.out_net);
      wr_data   = it_ff.set_value;
      r         = '0;
      unique case (st_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = 1'b0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               rc_in  = (q_item.kind == KIND_READ || q_item.kind == KIND_SET)
                        ? 3'd4 : 3'd0;
               vc_in  = 3'd0;
               vals_in = '0;
               st_in  = (q_item.kind == KIND_SET) ? ST_SETW : ST_READ;
            end
         end
         ST_SETW: begin
            wr_en = ({1'b0, it_ff.out_net} < NET_LIM) ? 1'b1 : 1'b0;
            st_in = ST_IDLE;
         end
         ST_READ: begin
            rd_req_in = 1'b1;
            rd_ok_in  = ({1'b0, rnet} < NET_LIM);
            vc_in     = rc_ff;
            if (rc_ff == 3'd4) begin
               st_in = ST_WAIT;
            end else if (rc_ff == 3'd3 || !used_ff[rc_ff[1:0] + 2'd1]) begin
               rc_in = 3'd4;
               if (it_ff.kind != KIND_ENUM) st_in = ST_WAIT;
            end else begin
               rc_in = rc_ff + 3'd1;
            end
         end
         ST_WAIT: begin
            st_in = ST_EXEC;
            ec_in = 3'd0;
         end
         ST_EXEC: begin
            if (out_ok) begin
               if (it_ff.kind == KIND_EVAL) begin
                  r.net_value = eval_bit;
                  r.last      = 1'b1;
                  wr_en   = ({1'b0, it_ff.out_net} < NET_LIM);
                  wr_data = eval_bit;
                  st_in   = ST_IDLE;
               end else if (it_ff.kind == KIND_READ) begin
                  r.net_value = vals_ff[4];
                  r.last      = 1'b1;
                  st_in       = ST_IDLE;
               end else begin
                  st_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_ok) begin
               if (ec_ff == 3'd4 || !used_ff[ec_ff[1:0]]) begin
                  r.fault_net    = it_ff.out_net;
                  r.fault_value  = ~vals_ff[4];
                  r.effect_net   = it_ff.out_net;
                  r.effect_value = ~vals_ff[4];
                  r.last         = 1'b1;
                  st_in          = ST_IDLE;
               end else begin
                  r.fault_net    = knet;
                  r.fault_value  = ~vals_ff[ec_ff];
                  r.effect_net   = it_ff.out_net;
                  r.effect_value = gate_fn(it_ff.gate_type, fv, used_ff);
                  ec_in          = ec_ff + 3'd1;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (rd_req_ff) vals_in[vc_ff] = rd_data & rd_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_CLEAR;
         clr_ff    <= '0;
         rsp_valid <= 1'b0;
         rd_req_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         rd_req_ff <= rd_req_in;
         if ((st_ff == ST_EXEC && it_ff.kind != KIND_ENUM && out_ok)
             || (st_ff == ST_EMIT && out_ok)) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
      rc_ff    <= rc_in;
      vc_ff    <= vc_in;
      vals_ff  <= vals_in;
      ec_ff    <= ec_in;
      rd_ok_ff <= rd_ok_in;
      if (q_take) begin
         it_ff   <= q_item;
         used_ff <= q_used;
      end
      if ((st_ff == ST_EXEC && it_ff.kind != KIND_ENUM && out_ok)
          || (st_ff == ST_EMIT && out_ok)) begin
         rsp_item <= r;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> st_ff == ST_IDLE) else $error("take while busy");
   a_no_write_emit: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_EMIT |-> !wr_en) else $error("store write during enumerate");
endmodule

@@ src/gate_eval_and_fault_enumerator.sv @@
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_item (gef_pkg::req_type)
// rsp      out        rsp_valid/rsp_stall  rsp_item (gef_pkg::rsp_type)
// After reset the store is swept to zero, one net a cycle; items queue
// meanwhile. Items run one at a time: a set writes the store; a read, an
// evaluate or an enumerate reads its nets in turn over the one store read
// port. A two-entry queue lets the front accept while results wait on rsp_stall.
module gate_eval_and_fault_enumerator
   import gef_pkg::*;
#(
   parameter int NET_COUNT = 1024,
   parameter int MAX_FANIN = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);
   logic       q_valid, q_take;
   req_type    q_item;
   logic [3:0] q_used;

   gef_front #(.MAX_FANIN(MAX_FANIN)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_item(req_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
      .q_used(q_used));

   gef_back #(.NET_COUNT(NET_COUNT)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_item(q_item), .q_used(q_used), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_item(rsp_item));
endmodule
